@@ sv/sds_pkg.sv @@
package sds_pkg;

  localparam int MAX_DIGITS = 15;
  localparam int OUT_DIGITS = MAX_DIGITS + 1;
  localparam int DIGIT_W    = 4;
  localparam int IN_W       = MAX_DIGITS * DIGIT_W;
  localparam int OUT_W      = OUT_DIGITS * DIGIT_W;
  localparam int LEN_W      = 5;

  localparam logic [DIGIT_W-1:0] BCD_MAX   = 4'd9;
  localparam logic [DIGIT_W:0]   BCD_RADIX = 5'd10;
  localparam logic [LEN_W-1:0]   LEN_ONE   = 5'd1;

  typedef logic [DIGIT_W-1:0] digit_t;

  // Per-digit carry/borrow generate and propagate terms plus the bad-digit flag.
  typedef struct packed {
    logic [MAX_DIGITS-1:0] add_gen;
    logic [MAX_DIGITS-1:0] add_prop;
    logic [MAX_DIGITS-1:0] sub_gen;
    logic [MAX_DIGITS-1:0] sub_prop;
    logic [MAX_DIGITS-1:0] rsub_gen;
    logic [MAX_DIGITS-1:0] rsub_prop;
    logic                  bad;
  } sds_flags_t;

endpackage

@@ sv/signed_decimal_subtractor.sv @@
// Signed packed-BCD subtractor: result = a - b, where a carries a sign flag and
// b is a non-negative magnitude, both DIGITS BCD digits wide (least significant
// nibble first, nibbles above DIGITS ignored). A negative a yields -(|a| + b),
// with the final carry kept in a sixteenth digit; otherwise the magnitudes are
// compared and the smaller is subtracted from the larger. The result is a sign,
// a 16-digit BCD magnitude and its count of significant digits (zero counts as
// one and is never negative). Any used nibble above nine sets digit_error and
// forces the result to plain zero. Rate: one item per cycle while the output is
// not stalled; each item passes through the four register stages. The
// four-stage pipeline is digit generate/propagate, carry and borrow chains, digit
// correction and select, then length count and final fixup. A stall on the output
// freezes all stages together and is passed straight back as in_stall.
module signed_decimal_subtractor
  import sds_pkg::*;
#(
  parameter int DIGITS = MAX_DIGITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [IN_W-1:0]  a_magnitude,
  input  logic             a_negative,
  input  logic [IN_W-1:0]  b_magnitude,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [OUT_W-1:0] result_digits,
  output logic             result_negative,
  output logic [LEN_W-1:0] result_length,
  output logic             digit_error
);

  // Whole pipeline advances together; held only when the output item is blocked.
  logic advance;
  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  // ---------------- Stage 1: mask, generate/propagate, bad-digit check
  logic [IN_W-1:0] a_used;
  logic [IN_W-1:0] b_used;
  sds_flags_t      flags_c;

  sds_digit_prep #(.DIGITS(DIGITS)) u_prep (
    .a_mag  (a_magnitude),
    .b_mag  (b_magnitude),
    .a_used (a_used),
    .b_used (b_used),
    .flags  (flags_c)
  );

  logic            v1;
  logic [IN_W-1:0] a1;
  logic [IN_W-1:0] b1;
  logic            neg1;
  sds_flags_t      flags1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (advance) begin
      v1 <= in_valid;
    end
    if (advance) begin
      a1     <= a_used;
      b1     <= b_used;
      neg1   <= a_negative;
      flags1 <= flags_c;
    end
  end

  // ---------------- Stage 2: decimal carry and borrow chains
  logic [MAX_DIGITS:0] add_c;
  logic [MAX_DIGITS:0] sub_c;
  logic [MAX_DIGITS:0] rsub_c;

  always_comb begin
    add_c[0]  = 1'b0;
    sub_c[0]  = 1'b0;
    rsub_c[0] = 1'b0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      add_c[i+1]  = flags1.add_gen[i]  | (flags1.add_prop[i]  & add_c[i]);
      sub_c[i+1]  = flags1.sub_gen[i]  | (flags1.sub_prop[i]  & sub_c[i]);
      rsub_c[i+1] = flags1.rsub_gen[i] | (flags1.rsub_prop[i] & rsub_c[i]);
    end
  end

  logic                v2;
  logic [IN_W-1:0]     a2;
  logic [IN_W-1:0]     b2;
  logic                neg2;
  logic                bad2;
  logic [MAX_DIGITS:0] add_c2;
  logic [MAX_DIGITS:0] sub_c2;
  logic [MAX_DIGITS:0] rsub_c2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (advance) begin
      v2 <= v1;
    end
    if (advance) begin
      a2      <= a1;
      b2      <= b1;
      neg2    <= neg1;
      bad2    <= flags1.bad;
      add_c2  <= add_c;
      sub_c2  <= sub_c;
      rsub_c2 <= rsub_c;
    end
  end

  // ---------------- Stage 3: per-digit correction and branch select
  logic [OUT_W-1:0] mag_c;
  logic             a_below_b;

  // Final borrow of a - b means a < b.
  assign a_below_b = sub_c2[MAX_DIGITS];

  always_comb begin
    digit_t           da;
    digit_t           db;
    logic [DIGIT_W:0] s;
    logic [DIGIT_W:0] t;
    mag_c = '0;
    s     = '0;
    t     = '0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      da = a2[i*DIGIT_W +: DIGIT_W];
      db = b2[i*DIGIT_W +: DIGIT_W];
      if (neg2) begin
        s = {1'b0, da} + {1'b0, db} + {{DIGIT_W{1'b0}}, add_c2[i]};
        if (s > {1'b0, BCD_MAX}) begin
          s = s - BCD_RADIX;
        end
        mag_c[i*DIGIT_W +: DIGIT_W] = s[DIGIT_W-1:0];
      end else begin
        if (a_below_b) begin
          t = {1'b0, db} - {1'b0, da} - {{DIGIT_W{1'b0}}, rsub_c2[i]};
        end else begin
          t = {1'b0, da} - {1'b0, db} - {{DIGIT_W{1'b0}}, sub_c2[i]};
        end
        if (t[DIGIT_W]) begin
          t = t + BCD_RADIX;
        end
        mag_c[i*DIGIT_W +: DIGIT_W] = t[DIGIT_W-1:0];
      end
    end
    // Extra top digit only ever holds the carry out of a magnitude add.
    mag_c[MAX_DIGITS*DIGIT_W +: DIGIT_W] = {{(DIGIT_W-1){1'b0}}, neg2 & add_c2[MAX_DIGITS]};
  end

  logic             v3;
  logic [OUT_W-1:0] mag3;
  logic             neg3;
  logic             bad3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (advance) begin
      v3 <= v2;
    end
    if (advance) begin
      mag3 <= mag_c;
      neg3 <= neg2 | a_below_b;
      bad3 <= bad2;
    end
  end

  // ---------------- Stage 4: significant length, zero sign, bad-digit override
  logic [LEN_W-1:0] len_c;
  logic             nonzero_c;

  always_comb begin
    len_c     = LEN_ONE;
    nonzero_c = 1'b0;
    for (int i = 0; i < OUT_DIGITS; i++) begin
      if (mag3[i*DIGIT_W +: DIGIT_W] != '0) begin
        len_c     = LEN_W'(i + 1);
        nonzero_c = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= v3;
    end
    if (advance) begin
      if (bad3) begin
        result_digits   <= '0;
        result_negative <= 1'b0;
        result_length   <= LEN_ONE;
      end else begin
        result_digits   <= mag3;
        result_negative <= neg3 & nonzero_c;
        result_length   <= len_c;
      end
      digit_error <= bad3;
    end
  end

  // ---------------- Checks
  a_bad_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && digit_error |->
      result_digits == '0 && !result_negative && result_length == LEN_ONE)
    else $error("bad-digit item did not produce plain zero");

  a_neg_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_negative |-> result_digits != '0)
    else $error("negative zero result");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> result_length >= LEN_ONE && result_length <= LEN_W'(OUT_DIGITS))
    else $error("result length out of range");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  a_entry_tracked: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> v1)
    else $error("accepted item lost at stage one");

endmodule

@@ sv/sds_digit_prep.sv @@
module sds_digit_prep
  import sds_pkg::*;
#(
  parameter int DIGITS = MAX_DIGITS
) (
  input  logic [IN_W-1:0] a_mag,
  input  logic [IN_W-1:0] b_mag,
  output logic [IN_W-1:0] a_used,
  output logic [IN_W-1:0] b_used,
  output sds_flags_t      flags
);

  always_comb begin
    digit_t          da;
    digit_t          db;
    logic [DIGIT_W:0] s;
    a_used = '0;
    b_used = '0;
    flags  = '0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (i < DIGITS) begin
        a_used[i*DIGIT_W +: DIGIT_W] = a_mag[i*DIGIT_W +: DIGIT_W];
        b_used[i*DIGIT_W +: DIGIT_W] = b_mag[i*DIGIT_W +: DIGIT_W];
      end
      da = a_used[i*DIGIT_W +: DIGIT_W];
      db = b_used[i*DIGIT_W +: DIGIT_W];
      s  = {1'b0, da} + {1'b0, db};
      flags.add_gen[i]   = (s > {1'b0, BCD_MAX});
      flags.add_prop[i]  = (s == {1'b0, BCD_MAX});
      flags.sub_gen[i]   = (da < db);
      flags.sub_prop[i]  = (da == db);
      flags.rsub_gen[i]  = (db < da);
      flags.rsub_prop[i] = (da == db);
      if ((da > BCD_MAX) || (db > BCD_MAX)) begin
        flags.bad = 1'b1;
      end
    end
  end

endmodule
